FILE: rtl/sfpr_pkg.sv
// Shared types and constants for the serial frame parameter responder.
// No dependencies.
package sfpr_pkg;

    localparam int MAX_PAYLOAD = 100;
    localparam int Q_DEPTH     = 2;

    localparam logic [7:0] HDR_BYTE = 8'hAA;
    localparam logic [7:0] DST_BYTE = 8'hFF;
    localparam logic [7:0] FN_READ  = 8'hE1;
    localparam logic [7:0] FN_WRITE = 8'hE2;
    localparam logic [7:0] FN_ACK   = 8'h00;

    localparam logic [15:0] PARAM_ID_RST  = 16'd10;
    localparam logic [31:0] STORED_RST    = 32'd123;

    // register byte addresses (index 0 at 0)
    localparam logic [2:0] ADDR_PARAM_ID = 3'd0;

    typedef enum logic {
        CMD_READ_RESP = 1'b0,
        CMD_WRITE_ACK = 1'b1
    } t_cmd_kind;

    // response job handed from the receive side to the transmit side
    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] id;     // read: requested id
        logic [31:0] value;  // read: returned value
        logic [7:0]  rsum;   // ack: sum byte of the request
        logic [7:0]  radd;   // ack: add byte of the request
    } t_cmd;

endpackage

FILE: rtl/serial_frame_param_responder.sv
// Top level of the serial frame parameter responder: APB register, receive
// front end, job queue and transmit back end. Depends on sfpr_pkg and the
// sfpr_* modules.
//
// Usage:
//  - s_axis carries received serial bytes (tdata = rx_byte). Request frames:
//    AA, address, function, length (<= 100), payload, sum, add.
//  - m_axis carries response bytes (tdata = tx_byte, tuser = frame_end).
//    A good read request (E1) answers with a 12-byte E2 frame holding the id
//    and the stored value (0 for a foreign id); a good write request (E2)
//    updates the value on an id match and answers with a 9-byte ack frame.
//  - APB register 0 (byte address 0) holds param_id, reset 10.
//  - One input byte is taken per cycle while the job queue has room. The
//    first response byte follows the add byte through the queue entry, the
//    transmit job register and the output register; then one byte per
//    cycle while m_axis_tready is high, frames back to back. The transmit
//    side sets the sustained rate: six request bytes draw twelve in reply.
//  - When the receiver stalls, the output register holds its byte, the
//    transmit side waits, the two-entry queue fills and s_axis_tready drops.
//  - Synchronous active-low reset: parser hunts for a header, queue and
//    output are emptied, the stored value returns to 123.
module serial_frame_param_responder
    import sfpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // response byte stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
    output logic        m_axis_tuser,   // [0] frame_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_param_id;

    logic in_accept;
    logic q_push;
    logic q_pop;
    logic q_valid;
    logic q_full;
    t_cmd push_cmd;
    t_cmd q_cmd;

    // APB: always ready, register index taken from address bit 2
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_PARAM_ID[2]) ? {16'd0, r_param_id} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_param_id <= PARAM_ID_RST;
        end else if (psel && penable && pwrite && (paddr[2] == ADDR_PARAM_ID[2])) begin
            r_param_id <= pwdata[15:0];
        end
    end

    // input stalls only while the job queue is full
    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    sfpr_rx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_byte     (s_axis_tdata),
        .i_param_id (r_param_id),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    sfpr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    sfpr_tx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tuser)
    );

endmodule

FILE: rtl/sfpr_rx_front.sv
// Receive side: deframes request bytes, checks sum/add bytes, owns the
// stored parameter value and queues response jobs. Depends on sfpr_pkg.
module sfpr_rx_front
    import sfpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_param_id,
    output logic        o_push,
    output t_cmd        o_cmd
);

    typedef enum logic [6:0] {
        PH_HUNT = 7'b0000001,
        PH_ADDR = 7'b0000010,
        PH_FUNC = 7'b0000100,
        PH_LEN  = 7'b0001000,
        PH_PAY  = 7'b0010000,
        PH_SUM  = 7'b0100000,
        PH_ADD  = 7'b1000000
    } t_phase;

    t_phase      r_phase;
    logic [6:0]  r_len;
    logic [6:0]  r_cnt;
    logic [7:0]  r_func;
    logic [7:0]  r_sum;
    logic [7:0]  r_add;
    logic [7:0]  r_head [6];
    logic [7:0]  r_rsum;
    logic [31:0] r_value;

    logic [7:0]  n_sum;
    logic [7:0]  n_add;
    logic [6:0]  n_cnt;
    logic [15:0] head_id;
    logic        chk_ok;
    logic        id_hit;

    assign n_sum   = r_sum + i_byte;
    assign n_add   = r_add + n_sum;
    assign n_cnt   = r_cnt + 7'd1;
    assign head_id = {r_head[1], r_head[0]};
    assign chk_ok  = (r_rsum == r_sum) && (i_byte == r_add);
    assign id_hit  = (head_id == i_param_id);

    always_comb begin
        o_push       = 1'b0;
        o_cmd.kind   = CMD_READ_RESP;
        o_cmd.id     = head_id;
        o_cmd.value  = id_hit ? r_value : 32'd0;
        o_cmd.rsum   = r_rsum;
        o_cmd.radd   = i_byte;
        if (i_accept && (r_phase == PH_ADD) && chk_ok) begin
            if (r_func == FN_READ) begin
                o_push = 1'b1;
            end else if (r_func == FN_WRITE) begin
                o_push     = 1'b1;
                o_cmd.kind = CMD_WRITE_ACK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_cnt   <= '0;
            r_func  <= '0;
            r_sum   <= '0;
            r_add   <= '0;
            r_rsum  <= '0;
            r_value <= STORED_RST;
            for (int i = 0; i < 6; i++) r_head[i] <= '0;
        end else if (i_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_byte == HDR_BYTE) begin
                        r_sum   <= i_byte;
                        r_add   <= i_byte;
                        r_cnt   <= '0;
                        for (int i = 0; i < 6; i++) r_head[i] <= '0;
                        r_phase <= PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    r_sum   <= n_sum;
                    r_add   <= n_add;
                    r_phase <= PH_FUNC;
                end
                PH_FUNC: begin
                    r_sum   <= n_sum;
                    r_add   <= n_add;
                    r_func  <= i_byte;
                    r_phase <= PH_LEN;
                end
                PH_LEN: begin
                    if (i_byte > 8'(MAX_PAYLOAD)) begin
                        r_phase <= PH_HUNT;
                    end else begin
                        r_sum   <= n_sum;
                        r_add   <= n_add;
                        r_len   <= i_byte[6:0];
                        r_cnt   <= '0;
                        r_phase <= (i_byte == 8'd0) ? PH_SUM : PH_PAY;
                    end
                end
                PH_PAY: begin
                    r_sum <= n_sum;
                    r_add <= n_add;
                    if (r_cnt < 7'd6) r_head[r_cnt[2:0]] <= i_byte;
                    r_cnt <= n_cnt;
                    if (n_cnt >= r_len) r_phase <= PH_SUM;
                end
                PH_SUM: begin
                    r_rsum  <= i_byte;
                    r_phase <= PH_ADD;
                end
                PH_ADD: begin
                    r_phase <= PH_HUNT;
                    if (chk_ok && (r_func == FN_WRITE) && id_hit) begin
                        r_value <= {r_head[5], r_head[4], r_head[3], r_head[2]};
                    end
                end
                default: r_phase <= PH_HUNT;
            endcase
        end
    end

endmodule

FILE: rtl/sfpr_cmd_queue.sv
// Two-entry job queue between receive and transmit sides.
// Depends on sfpr_pkg.
module sfpr_cmd_queue
    import sfpr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);

    localparam int PW = $clog2(Q_DEPTH);

    t_cmd          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (PW+1)'(Q_DEPTH));
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == PW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/sfpr_tx_back.sv
// Transmit side: turns one queued job into a response frame with trailing
// sum and add bytes, one byte per cycle unless held. Depends on sfpr_pkg.
module sfpr_tx_back
    import sfpr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    localparam logic [3:0] READ_BODY = 4'd10;
    localparam logic [3:0] ACK_BODY  = 4'd7;

    t_cmd       r_cmd;
    logic       r_busy;
    logic [3:0] r_idx;
    logic [7:0] r_s;
    logic [7:0] r_a;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [3:0] body_len;
    logic [7:0] body_byte;
    logic [7:0] n_s;
    logic       in_body;
    logic       is_last;
    logic       can_emit;
    logic       load;
    logic [7:0] emit_byte;

    assign body_len = (r_cmd.kind == CMD_READ_RESP) ? READ_BODY : ACK_BODY;
    assign in_body  = (r_idx < body_len);
    assign is_last  = (r_idx == body_len + 4'd1);
    assign can_emit = r_busy && (!r_out_valid || i_ready);
    assign load     = i_q_valid && (!r_busy || (can_emit && is_last));
    assign o_q_pop  = load;
    assign n_s      = r_s + body_byte;

    always_comb begin
        body_byte = 8'd0;
        case (r_idx)
            4'd0: body_byte = HDR_BYTE;
            4'd1: body_byte = DST_BYTE;
            4'd2: body_byte = (r_cmd.kind == CMD_READ_RESP) ? FN_WRITE : FN_ACK;
            4'd3: body_byte = (r_cmd.kind == CMD_READ_RESP) ? 8'd6 : 8'd3;
            4'd4: body_byte = (r_cmd.kind == CMD_READ_RESP) ? r_cmd.id[7:0] : FN_WRITE;
            4'd5: body_byte = (r_cmd.kind == CMD_READ_RESP) ? r_cmd.id[15:8] : r_cmd.rsum;
            4'd6: body_byte = (r_cmd.kind == CMD_READ_RESP) ? r_cmd.value[7:0] : r_cmd.radd;
            4'd7: body_byte = r_cmd.value[15:8];
            4'd8: body_byte = r_cmd.value[23:16];
            4'd9: body_byte = r_cmd.value[31:24];
            default: body_byte = 8'd0;
        endcase
    end

    always_comb begin
        if (in_body)                emit_byte = body_byte;
        else if (r_idx == body_len) emit_byte = r_s;
        else                        emit_byte = r_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_s         <= '0;
            r_a         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_s    <= '0;
                r_a    <= '0;
            end else if (can_emit) begin
                r_idx <= r_idx + 4'd1;
                if (in_body) begin
                    r_s <= n_s;
                    r_a <= r_a + n_s;
                end
                if (is_last) r_busy <= 1'b0;
            end
            if (can_emit)     r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_cmd <= i_q_cmd;
        if (can_emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= is_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule
